### rtl/sbpi_pkg.sv
// sbpi_pkg: shared widths, codes and sideband types for the swept box pair impact block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package sbpi_pkg;
   // Distance width in 2^-17 units, with headroom for size offsets
   localparam int DW = 36;
   // Time of impact width (Q1.16, 1.0 included)
   localparam int TW = 17;
   // Quotient bits: one per divider stage
   localparam int DIV_STEPS = TW;
   // Edges from an input transfer to the edge that takes its result
   localparam int LATENCY = DIV_STEPS + 4;
   localparam logic [TW-1:0] TIME_ONE = 17'h10000;

   // Normal codes, 2-bit signed
   localparam logic [1:0] NORM_NONE = 2'b00;
   localparam logic [1:0] NORM_POS  = 2'b01;
   localparam logic [1:0] NORM_NEG  = 2'b11;

   // Per-item data that rides beside the dividers
   typedef struct packed {
      logic [TW-1:0] best;
      logic          ov_x;
      logic          ov_y;
      logic          pos_x;
      logic          pos_y;
   } side_type;
endpackage

### rtl/swept_box_pair_impact.sv
// swept_box_pair_impact: top level of the swept box pair impact pipeline.
// Depends on sbpi_pkg and sbpi_axis_div.
//
// Usage:
//  - Input channel: drive the req_ fields and raise start; a transfer happens at each
//    rising edge with start high and busy low. busy is high only during reset, so a
//    new box pair is taken every cycle.
//  - Result channel: rsp_strobe is high for one cycle with rsp_hit, rsp_impact_time,
//    rsp_normal_x and rsp_normal_y; one result per input transfer, in order.
//  - Throughput is one pair per cycle outside reset.
//  - The depth is set by the two 17-stage restoring dividers (one quotient bit per
//    stage), one per axis, plus an offset stage, a numerator stage, a sign fold stage
//    and the output select stage.
//  - Reset clears every valid bit; items in flight are dropped.
//  - The receiver cannot stall; results are shown once and not held.
//  - The normal is for box A; box B's normal is its negation.
`timescale 1ns / 1ps
module swept_box_pair_impact (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [31:0]          req_sep_x,
   input  logic signed [31:0]          req_sep_y,
   input  logic signed [31:0]          req_motion_x,
   input  logic signed [31:0]          req_motion_y,
   input  logic [30:0]                 req_width_a,
   input  logic [30:0]                 req_height_a,
   input  logic [30:0]                 req_width_b,
   input  logic [30:0]                 req_height_b,
   input  logic [sbpi_pkg::TW-1:0]     req_best_time,
   output logic                        rsp_strobe,
   output logic                        rsp_hit,
   output logic [sbpi_pkg::TW-1:0]     rsp_impact_time,
   output logic signed [1:0]           rsp_normal_x,
   output logic signed [1:0]           rsp_normal_y
);
   import sbpi_pkg::*;

   assign busy = reset;

   // Stage 1: start distances in 2^-17 units
   logic                 s1_vld_ff;
   logic signed [DW-1:0] s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic signed [31:0]   s1_mx_ff, s1_my_ff;
   logic [30:0]          s1_wa_ff, s1_ha_ff, s1_wb_ff, s1_hb_ff;
   logic [TW-1:0]        s1_best_ff;

   always_comb begin
      s1_dx_in = {{(DW-33){req_sep_x[31]}}, req_sep_x, 1'b0}
                 + $signed({{(DW-31){1'b0}}, req_width_a})
                 - $signed({{(DW-31){1'b0}}, req_width_b});
      s1_dy_in = {{(DW-33){req_sep_y[31]}}, req_sep_y, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_dx_ff   <= s1_dx_in;
      s1_dy_ff   <= s1_dy_in;
      s1_mx_ff   <= req_motion_x;
      s1_my_ff   <= req_motion_y;
      s1_wa_ff   <= req_width_a;
      s1_ha_ff   <= req_height_a;
      s1_wb_ff   <= req_width_b;
      s1_hb_ff   <= req_height_b;
      s1_best_ff <= req_best_time;
   end

   // Stage 2: extend by the leading size, double the motion, check overlaps
   logic                 s2_vld_ff;
   logic signed [DW-1:0] s2_nx_ff, s2_ny_ff, s2_nx_in, s2_ny_in;
   logic signed [DW-1:0] s2_ddx_ff, s2_ddy_ff, s2_ddx_in, s2_ddy_in;
   logic                 s2_zx_ff, s2_zy_ff, s2_zx_in, s2_zy_in;
   side_type             s2_side_ff, s2_side_in;
   logic signed [DW-1:0] wa2, wb2, ha2, hb2;

   always_comb begin
      wa2 = {{(DW-32){1'b0}}, s1_wa_ff, 1'b0};
      wb2 = {{(DW-32){1'b0}}, s1_wb_ff, 1'b0};
      ha2 = {{(DW-32){1'b0}}, s1_ha_ff, 1'b0};
      hb2 = {{(DW-32){1'b0}}, s1_hb_ff, 1'b0};
      s2_zx_in = (s1_mx_ff == '0);
      s2_zy_in = (s1_my_ff == '0);
      s2_side_in.best  = s1_best_ff;
      s2_side_in.pos_x = ~s1_mx_ff[31] & ~s2_zx_in;
      s2_side_in.pos_y = ~s1_my_ff[31] & ~s2_zy_in;
      s2_nx_in = s2_side_in.pos_x ? s1_dx_ff - wa2 : s1_dx_ff + wb2;
      s2_ny_in = s2_side_in.pos_y ? s1_dy_ff - ha2 : s1_dy_ff + hb2;
      s2_ddx_in = {{(DW-33){s1_mx_ff[31]}}, s1_mx_ff, 1'b0};
      s2_ddy_in = {{(DW-33){s1_my_ff[31]}}, s1_my_ff, 1'b0};
      // X time needs Y overlap, Y time needs X overlap
      s2_side_in.ov_x = ~((-hb2 > s1_dy_ff) | (s1_dy_ff > ha2));
      s2_side_in.ov_y = ~((-wb2 > s1_dx_ff) | (s1_dx_ff > wa2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_nx_ff   <= s2_nx_in;
      s2_ny_ff   <= s2_ny_in;
      s2_ddx_ff  <= s2_ddx_in;
      s2_ddy_ff  <= s2_ddy_in;
      s2_zx_ff   <= s2_zx_in;
      s2_zy_ff   <= s2_zy_in;
      s2_side_ff <= s2_side_in;
   end

   // Stage 3: fold signs so the denominator is positive, drop negative times
   logic                 s3_vld_ff;
   logic signed [DW-1:0] s3_nx_ff, s3_ny_ff, s3_nx_in, s3_ny_in;
   logic signed [DW-1:0] s3_dx_ff, s3_dy_ff, s3_dx_in, s3_dy_in;
   logic                 s3_okx_ff, s3_oky_ff, s3_okx_in, s3_oky_in;
   side_type             s3_side_ff;

   always_comb begin
      s3_nx_in  = s2_side_ff.pos_x ? s2_nx_ff : -s2_nx_ff;
      s3_ny_in  = s2_side_ff.pos_y ? s2_ny_ff : -s2_ny_ff;
      s3_dx_in  = s2_side_ff.pos_x ? s2_ddx_ff : -s2_ddx_ff;
      s3_dy_in  = s2_side_ff.pos_y ? s2_ddy_ff : -s2_ddy_ff;
      s3_okx_in = ~s2_zx_ff & ~s3_nx_in[DW-1];
      s3_oky_in = ~s2_zy_ff & ~s3_ny_in[DW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_nx_ff   <= s3_nx_in;
      s3_ny_ff   <= s3_ny_in;
      s3_dx_ff   <= s3_dx_in;
      s3_dy_ff   <= s3_dy_in;
      s3_okx_ff  <= s3_okx_in;
      s3_oky_ff  <= s3_oky_in;
      s3_side_ff <= s2_side_ff;
   end

   // Divide both axes
   logic          dvx_vld, dvx_ok, dvy_vld, dvy_ok;
   logic [TW-1:0] dvx_quo, dvy_quo;

   sbpi_axis_div u_div_x (
      .clock   (clock),
      .reset   (reset),
      .vld_in  (s3_vld_ff),
      .ok_in   (s3_okx_ff),
      .num_in  (s3_nx_ff),
      .den_in  (s3_dx_ff),
      .vld_out (dvx_vld),
      .ok_out  (dvx_ok),
      .quo_out (dvx_quo)
   );

   sbpi_axis_div u_div_y (
      .clock   (clock),
      .reset   (reset),
      .vld_in  (s3_vld_ff),
      .ok_in   (s3_oky_ff),
      .num_in  (s3_ny_ff),
      .den_in  (s3_dy_ff),
      .vld_out (dvy_vld),
      .ok_out  (dvy_ok),
      .quo_out (dvy_quo)
   );

   // Hold sideband beside the dividers
   side_type side_ff [DIV_STEPS];

   always_ff @(posedge clock) begin
      side_ff[0] <= s3_side_ff;
      for (int k = 1; k < DIV_STEPS; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // Output stage: pick the earlier axis, X on a tie
   side_type      sd;
   logic          vx, vy, sel_x, sel_y;
   logic          hit_in;
   logic [TW-1:0] time_in;
   logic [1:0]    nx_in, ny_in;

   always_comb begin
      sd    = side_ff[DIV_STEPS-1];
      vx    = dvx_ok & sd.ov_x;
      vy    = dvy_ok & sd.ov_y;
      sel_x = vx & (dvx_quo <= sd.best) & (~vy | (dvx_quo <= dvy_quo));
      sel_y = ~sel_x & vy & (dvy_quo <= sd.best);
      hit_in  = sel_x | sel_y;
      time_in = sd.best;
      nx_in   = NORM_NONE;
      ny_in   = NORM_NONE;
      if (sel_x) begin
         time_in = dvx_quo;
         nx_in   = sd.pos_x ? NORM_NEG : NORM_POS;
      end else if (sel_y) begin
         time_in = dvy_quo;
         ny_in   = sd.pos_y ? NORM_NEG : NORM_POS;
      end
   end

   logic out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dvx_vld & dvy_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit         <= hit_in;
      rsp_impact_time <= time_in;
      rsp_normal_x    <= nx_in;
      rsp_normal_y    <= ny_in;
   end

   assign rsp_strobe = out_vld_ff;
endmodule

### rtl/sbpi_div_step.sv
// sbpi_div_step: one registered restoring-division step (one quotient bit).
// Depends on sbpi_pkg.
`timescale 1ns / 1ps
module sbpi_div_step #(
   parameter bit FIRST = 1'b0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    vld_in,
   input  logic                    ok_in,
   input  logic [sbpi_pkg::DW-1:0] rem_in,
   input  logic [sbpi_pkg::DW-1:0] den_in,
   input  logic [sbpi_pkg::TW-1:0] quo_in,
   output logic                    vld_ff,
   output logic                    ok_ff,
   output logic [sbpi_pkg::DW-1:0] rem_ff,
   output logic [sbpi_pkg::DW-1:0] den_ff,
   output logic [sbpi_pkg::TW-1:0] quo_ff
);
   import sbpi_pkg::*;

   logic [DW-1:0] trial;
   logic [DW:0]   diff;
   logic          take;
   logic [DW-1:0] rem_in_n;
   logic          ok_in_n;

   // Shift, trial subtract, keep or restore
   always_comb begin
      trial    = FIRST ? rem_in : {rem_in[DW-2:0], 1'b0};
      diff     = {1'b0, trial} - {1'b0, den_in};
      take     = ~diff[DW];
      rem_in_n = take ? diff[DW-1:0] : trial;
      // First step: a numerator above the denominator means time past 1.0
      ok_in_n  = ok_in & ~(FIRST & take & (diff[DW-1:0] != '0));
   end

   // Advance valid, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      ok_ff  <= ok_in_n;
      rem_ff <= rem_in_n;
      den_ff <= den_in;
      quo_ff <= {quo_in[TW-2:0], take};
   end
endmodule

### rtl/sbpi_axis_div.sv
// sbpi_axis_div: pipelined divider for one axis, floor(num * 65536 / den) with num <= den.
// Depends on sbpi_pkg and sbpi_div_step.
`timescale 1ns / 1ps
module sbpi_axis_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    vld_in,
   input  logic                    ok_in,
   input  logic [sbpi_pkg::DW-1:0] num_in,
   input  logic [sbpi_pkg::DW-1:0] den_in,
   output logic                    vld_out,
   output logic                    ok_out,
   output logic [sbpi_pkg::TW-1:0] quo_out
);
   import sbpi_pkg::*;

   logic          vld_tap [DIV_STEPS+1];
   logic          ok_tap  [DIV_STEPS+1];
   logic [DW-1:0] rem_tap [DIV_STEPS+1];
   logic [DW-1:0] den_tap [DIV_STEPS+1];
   logic [TW-1:0] quo_tap [DIV_STEPS+1];

   assign vld_tap[0] = vld_in;
   assign ok_tap[0]  = ok_in;
   assign rem_tap[0] = num_in;
   assign den_tap[0] = den_in;
   assign quo_tap[0] = '0;

   // One stage per quotient bit, most significant first
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      sbpi_div_step #(.FIRST(k == 0)) u_step (
         .clock  (clock),
         .reset  (reset),
         .vld_in (vld_tap[k]),
         .ok_in  (ok_tap[k]),
         .rem_in (rem_tap[k]),
         .den_in (den_tap[k]),
         .quo_in (quo_tap[k]),
         .vld_ff (vld_tap[k+1]),
         .ok_ff  (ok_tap[k+1]),
         .rem_ff (rem_tap[k+1]),
         .den_ff (den_tap[k+1]),
         .quo_ff (quo_tap[k+1])
      );
   end

   assign vld_out = vld_tap[DIV_STEPS];
   assign ok_out  = ok_tap[DIV_STEPS];
   assign quo_out = quo_tap[DIV_STEPS];
endmodule

### rtl/sbpi_checker.sv
// sbpi_checker: port-level checks for swept_box_pair_impact, bound to the top level.
// Depends on sbpi_pkg.
`timescale 1ns / 1ps
module sbpi_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_strobe,
   input logic                    rsp_hit,
   input logic [sbpi_pkg::TW-1:0] rsp_impact_time,
   input logic [1:0]              rsp_normal_x,
   input logic [1:0]              rsp_normal_y
);
   import sbpi_pkg::*;

   // Every result comes from a transfer a fixed latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start & ~busy, LATENCY))
      else $error("result without matching input transfer");

   // A miss carries no normal
   a_miss_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |-> (rsp_normal_x == NORM_NONE && rsp_normal_y == NORM_NONE))
      else $error("normal set on a miss");

   // A hit has exactly one axis normal
   a_hit_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit) |-> ((rsp_normal_x != NORM_NONE) != (rsp_normal_y != NORM_NONE)))
      else $error("hit without a single axis normal");

   // A hit time never passes 1.0
   a_hit_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit) |-> (rsp_impact_time <= TIME_ONE))
      else $error("hit time beyond one step");
endmodule

bind swept_box_pair_impact sbpi_checker u_sbpi_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_hit         (rsp_hit),
   .rsp_impact_time (rsp_impact_time),
   .rsp_normal_x    (rsp_normal_x),
   .rsp_normal_y    (rsp_normal_y)
);
